[sv/pmlesc_pkg.sv]
`default_nettype none
package pmlesc_pkg;

    localparam int ID_WIDTH = 16;

    typedef logic [ID_WIDTH-1:0] id_t;

    typedef enum logic [4:0] {
        ST_IDLE         = 5'd0,
        ST_STARTING     = 5'd1,
        ST_EXECUTE      = 5'd2,
        ST_COMPLETING   = 5'd3,
        ST_COMPLETE     = 5'd4,
        ST_RESETTING    = 5'd5,
        ST_HOLDING      = 5'd6,
        ST_HELD         = 5'd7,
        ST_UNHOLDING    = 5'd8,
        ST_SUSPENDING   = 5'd9,
        ST_SUSPENDED    = 5'd10,
        ST_UNSUSPENDING = 5'd11,
        ST_STOPPING     = 5'd12,
        ST_STOPPED      = 5'd13,
        ST_ABORTING     = 5'd14,
        ST_ABORTED      = 5'd15,
        ST_CLEARING     = 5'd16
    } exec_state_t;

    typedef enum logic [1:0] {
        OCC_FREE     = 2'd0,
        OCC_OCCUPIED = 2'd1,
        OCC_PRIORITY = 2'd2,
        OCC_LOCAL    = 2'd3
    } occ_state_t;

    typedef enum logic [4:0] {
        ACT_START     = 5'd0,
        ACT_RESET     = 5'd1,
        ACT_HOLD      = 5'd2,
        ACT_UNHOLD    = 5'd3,
        ACT_SUSPEND   = 5'd4,
        ACT_UNSUSPEND = 5'd5,
        ACT_ABORT     = 5'd6,
        ACT_STOP      = 5'd7,
        ACT_CLEAR     = 5'd8,
        ACT_COMPLETE  = 5'd9,
        ACT_FINISH    = 5'd10,
        ACT_SET_MODE  = 5'd11,
        ACT_OCCUPY    = 5'd12,
        ACT_PRIORITY  = 5'd13,
        ACT_FREE      = 5'd14,
        ACT_LOCAL_ON  = 5'd15,
        ACT_LOCAL_OFF = 5'd16
    } action_t;

    localparam logic [0:0] REG_LOCAL_ID = 1'b0;
    localparam logic [15:0] LOCAL_ID_RESET = 16'hFFFF;

endpackage
`default_nettype wire

[sv/packml_execution_state_controller.sv]
// PackML-style execution state controller. Each request carries one command
// (execution order, finish, set_mode, occupy, priority, free, local_on or
// local_off) and yields exactly one result: the execution state, occupation,
// current and previous occupier and mode after the command, plus a flag that
// tells whether anything changed. A request is captured in an input register
// and applied once no waiting result blocks it: short decode logic updates
// the state registers, which also serve as the result register. One request
// per cycle is sustained while out_ready is high. A waiting result stalls a
// request held in the input register, which then holds in_ready low. The
// local_id register (APB address 0) supplies the occupier ID used under local
// override; write it only while no request is in flight.
`default_nettype none
module packml_execution_state_controller (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [2:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic      [31:0]            prdata,
    output logic                        pready,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [4:0]             action,
    input  wire logic [15:0]            requester_id,
    input  wire logic [1:0]             mode_value,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [4:0]                  exec_state,
    output logic [1:0]                  occupation,
    output logic [15:0]                 current_occupier,
    output logic [15:0]                 previous_occupier,
    output logic [1:0]                  mode_now,
    output logic                        changed
);
    import pmlesc_pkg::*;

    logic [15:0] local_id_reg, local_id_next;

    logic        in_valid_reg, in_valid_next;
    logic [4:0]  act_reg, act_next;
    id_t         req_reg, req_next;
    logic [1:0]  mode_in_reg, mode_in_next;

    logic        out_valid_reg, out_valid_next;
    logic        changed_reg, changed_next;

    exec_state_t exec_reg, exec_next;
    occ_state_t  occ_reg, occ_next;
    id_t         occupier_reg, occupier_next;
    id_t         prior_occupier_reg, prior_occupier_next;
    id_t         saved_occupier_reg, saved_occupier_next;
    logic [1:0]  mode_reg, mode_next;

    logic        advance;
    logic        cfg_write;
    action_t     act;
    logic        order_cmd;

    // APB
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_LOCAL_ID) ? {16'd0, local_id_reg} : 32'd0;

    always_comb
    begin
        local_id_next = local_id_reg;
        if (cfg_write && paddr[2] == REG_LOCAL_ID)
        begin
            local_id_next = pwdata[15:0];
        end
    end

    // Pipeline handshake
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        act_next      = act_reg;
        req_next      = req_reg;
        mode_in_next  = mode_in_reg;
        if (in_ready)
        begin
            in_valid_next = in_valid;
            if (in_valid)
            begin
                act_next     = action;
                req_next     = requester_id[ID_WIDTH-1:0];
                mode_in_next = mode_value;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign act       = action_t'(act_reg);
    assign order_cmd = (act_reg <= 5'(ACT_COMPLETE));

    // Execution state: next state
    always_comb
    begin
        exec_next = exec_reg;
        if (advance && order_cmd)
        begin
            case (exec_reg)
                ST_IDLE:
                begin
                    if (act == ACT_START) exec_next = ST_STARTING;
                end
                ST_EXECUTE:
                begin
                    if (act == ACT_COMPLETE)     exec_next = ST_COMPLETING;
                    else if (act == ACT_HOLD)    exec_next = ST_HOLDING;
                    else if (act == ACT_SUSPEND) exec_next = ST_SUSPENDING;
                end
                ST_COMPLETE:
                begin
                    if (act == ACT_RESET) exec_next = ST_RESETTING;
                end
                ST_HELD:
                begin
                    if (act == ACT_UNHOLD) exec_next = ST_UNHOLDING;
                end
                ST_SUSPENDED:
                begin
                    if (act == ACT_UNSUSPEND) exec_next = ST_UNSUSPENDING;
                end
                ST_STOPPED:
                begin
                    if (act == ACT_RESET) exec_next = ST_RESETTING;
                end
                ST_ABORTED:
                begin
                    if (act == ACT_CLEAR) exec_next = ST_CLEARING;
                end
                default:
                begin
                    exec_next = exec_reg;
                end
            endcase
            // stop from idle up to unsuspending; abort from all but aborting and aborted
            if (act == ACT_STOP && exec_reg <= ST_UNSUSPENDING)
            begin
                exec_next = ST_STOPPING;
            end
            if (act == ACT_ABORT && exec_reg != ST_ABORTING && exec_reg != ST_ABORTED)
            begin
                exec_next = ST_ABORTING;
            end
        end
        else if (advance && act == ACT_FINISH)
        begin
            case (exec_reg)
                ST_STARTING:     exec_next = ST_EXECUTE;
                ST_EXECUTE:      exec_next = ST_COMPLETING;
                ST_COMPLETING:   exec_next = ST_COMPLETE;
                ST_RESETTING:    exec_next = ST_IDLE;
                ST_HOLDING:      exec_next = ST_HELD;
                ST_UNHOLDING:    exec_next = ST_EXECUTE;
                ST_SUSPENDING:   exec_next = ST_SUSPENDED;
                ST_UNSUSPENDING: exec_next = ST_EXECUTE;
                ST_STOPPING:     exec_next = ST_STOPPED;
                ST_STOPPED:      exec_next = ST_IDLE;
                ST_ABORTING:     exec_next = ST_ABORTED;
                ST_CLEARING:     exec_next = ST_STOPPED;
                default:         exec_next = exec_reg;
            endcase
        end
    end

    // Occupation, occupier IDs and mode
    always_comb
    begin
        occ_next            = occ_reg;
        occupier_next       = occupier_reg;
        prior_occupier_next = prior_occupier_reg;
        saved_occupier_next = saved_occupier_reg;
        mode_next           = mode_reg;
        if (advance)
        begin
            case (act)
                ACT_SET_MODE:
                begin
                    mode_next = mode_in_reg;
                end
                ACT_OCCUPY:
                begin
                    if (occ_reg == OCC_FREE)
                    begin
                        occupier_next = req_reg;
                        occ_next      = OCC_OCCUPIED;
                    end
                end
                ACT_PRIORITY:
                begin
                    if (occ_reg == OCC_FREE || occ_reg == OCC_OCCUPIED)
                    begin
                        prior_occupier_next = occupier_reg;
                        occupier_next       = req_reg;
                        occ_next            = OCC_PRIORITY;
                    end
                end
                ACT_FREE:
                begin
                    // promote the previous occupier
                    if (occupier_reg == req_reg)
                    begin
                        occupier_next       = prior_occupier_reg;
                        prior_occupier_next = '0;
                        occ_next = (prior_occupier_reg == '0) ? OCC_FREE : OCC_OCCUPIED;
                    end
                end
                ACT_LOCAL_ON:
                begin
                    saved_occupier_next = occupier_reg;
                    occ_next            = OCC_LOCAL;
                    occupier_next       = local_id_reg[ID_WIDTH-1:0];
                end
                ACT_LOCAL_OFF:
                begin
                    occupier_next = saved_occupier_reg;
                    if (saved_occupier_reg == '0)      occ_next = OCC_FREE;
                    else if (prior_occupier_reg == '0) occ_next = OCC_OCCUPIED;
                    else                               occ_next = OCC_PRIORITY;
                end
                default:
                begin
                    occ_next = occ_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        changed_next = changed_reg;
        if (advance)
        begin
            changed_next = (exec_next != exec_reg) || (occ_next != occ_reg)
                        || (occupier_next != occupier_reg)
                        || (prior_occupier_next != prior_occupier_reg)
                        || (saved_occupier_next != saved_occupier_reg)
                        || (mode_next != mode_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_id_reg       <= LOCAL_ID_RESET;
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            changed_reg        <= 1'b0;
            exec_reg           <= ST_IDLE;
            occ_reg            <= OCC_FREE;
            occupier_reg       <= '0;
            prior_occupier_reg <= '0;
            saved_occupier_reg <= '0;
            mode_reg           <= 2'd0;
        end
        else
        begin
            local_id_reg       <= local_id_next;
            in_valid_reg       <= in_valid_next;
            out_valid_reg      <= out_valid_next;
            changed_reg        <= changed_next;
            exec_reg           <= exec_next;
            occ_reg            <= occ_next;
            occupier_reg       <= occupier_next;
            prior_occupier_reg <= prior_occupier_next;
            saved_occupier_reg <= saved_occupier_next;
            mode_reg           <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        req_reg     <= req_next;
        mode_in_reg <= mode_in_next;
    end

    // Result outputs come straight from the state registers
    assign out_valid         = out_valid_reg;
    assign exec_state        = exec_reg;
    assign occupation        = occ_reg;
    assign current_occupier  = 16'(occupier_reg);
    assign previous_occupier = 16'(prior_occupier_reg);
    assign mode_now          = mode_reg;
    assign changed           = changed_reg;

    a_state_holds_without_advance: assert property (
        @(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(exec_reg) && $stable(occ_reg) && $stable(occupier_reg)
                      && $stable(mode_reg))
    ) else $error("state moved without an applied request");

    a_unchanged_flag_means_stable: assert property (
        @(posedge clk) disable iff (!rst_n)
        (advance && !changed_next) |=> ($stable(exec_reg) && $stable(occ_reg)
            && $stable(occupier_reg) && $stable(prior_occupier_reg)
            && $stable(saved_occupier_reg) && $stable(mode_reg))
    ) else $error("changed flag low but state moved");

    a_free_means_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        (occ_reg == OCC_FREE) |-> (occupier_reg == '0)
    ) else $error("free occupation with an occupier");

    a_advance_fills_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg
    ) else $error("applied request produced no result");

endmodule
`default_nettype wire
